[hw/rtl/pngenc_pkg.sv]
// pngenc_pkg: shared types, constants and helper functions of the PNG stream encoder.
// Used by the controller, datapath, top level, checker and the testbench.
`default_nettype none
package pngenc_pkg;

  localparam int unsigned DIM_BITS_DEF = 14;
  localparam int unsigned CFG_W        = 15;
  localparam int unsigned IDX_W        = 1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 1'd1;

  // input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

  localparam logic [63:0] PNG_SIG   = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;
  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;

  // byte positions inside the start sequence
  localparam logic [5:0] ST_LEN       = 6'd8;
  localparam logic [5:0] ST_IHDR_TYPE = 6'd12;
  localparam logic [5:0] ST_IHDR_DATA = 6'd16;
  localparam logic [5:0] ST_IHDR_CRC  = 6'd29;
  localparam logic [5:0] ST_ZLEN      = 6'd33;
  localparam logic [5:0] ST_IDAT_TYPE = 6'd37;
  localparam logic [5:0] ST_ZLIB      = 6'd41;
  localparam logic [5:0] ST_LAST      = 6'd42;

  // byte positions inside the trailer
  localparam logic [5:0] FIN_CRC       = 6'd4;
  localparam logic [5:0] FIN_IEND_LEN  = 6'd8;
  localparam logic [5:0] FIN_IEND_TYPE = 6'd12;
  localparam logic [5:0] FIN_IEND_CRC  = 6'd16;
  localparam logic [5:0] FIN_LAST      = 6'd19;

  localparam logic [2:0] HDR_LAST = 3'd4;
  localparam logic [2:0] RAW_LAST = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_HDR,
    OP_RAW,
    OP_FIN
  } op_e;

  // controller -> datapath
  typedef struct packed {
    op_e        op;
    logic [5:0] idx;
    logic       last;
    logic       pix_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;
    logic blk_zero;
    logic col_zero;
    logic img_last;
    logic can_emit;
  } stat_t;

  // byte k of a big-endian word
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    return 8'(v >> {~k, 3'b000});
  endfunction

  // CRC-32 (reflected) over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pngenc_if.sv]
// Stream interfaces of the PNG encoder: pixel input and byte output.
// Depends on nothing but plain logic types.
`default_nettype none
interface pngenc_pix_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, cmd, red, green, blue, alpha, input ready);
  modport sink (input valid, cmd, red, green, blue, alpha, output ready);
  modport mon (input valid, ready, cmd, red, green, blue, alpha);
endinterface

interface pngenc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink (input valid, out_byte, run_last, output ready);
  modport mon (input valid, ready, out_byte, run_last);
endinterface
`default_nettype wire

[hw/rtl/pngenc_ctrl.sv]
// pngenc_ctrl: sequencer that walks the start, block header, raw and trailer bytes.
// Depends on pngenc_pkg; drives the datapath through cmd_t, reads stat_t.
`default_nettype none
module pngenc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  output logic               in_ready_o,
  input  pngenc_pkg::stat_t  stat_i,
  output pngenc_pkg::cmd_t   cmd_o
);
  import pngenc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_PIX,
    S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [2:0] hcnt_q, hcnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hcnt_d  = hcnt_q;
    cmd_o   = '{op: OP_NONE, idx: cnt_q, last: 1'b0, pix_load: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == CMD_START) begin
            state_d = S_START;
            cnt_d   = '0;
          end else if (stat_i.busy) begin
            state_d        = S_PIX;
            cmd_o.pix_load = 1'b1;
            cnt_d          = stat_i.col_zero ? 6'd0 : 6'd1;
            hcnt_d         = '0;
          end
        end
      end
      S_START: begin
        if (stat_i.can_emit) begin
          cmd_o.op = OP_START;
          if (cnt_q == ST_LAST) begin
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      S_PIX: begin
        if (stat_i.can_emit) begin
          // a stored-block header goes ahead of the byte that opens a block
          if (stat_i.blk_zero) begin
            cmd_o.op  = OP_HDR;
            cmd_o.idx = {3'd0, hcnt_q};
            hcnt_d    = (hcnt_q == HDR_LAST) ? 3'd0 : hcnt_q + 3'd1;
          end else begin
            cmd_o.op = OP_RAW;
            if (cnt_q[2:0] == RAW_LAST) begin
              cmd_o.last = !stat_i.img_last;
              state_d    = stat_i.img_last ? S_FIN : S_IDLE;
              cnt_d      = '0;
            end else begin
              cnt_d = cnt_q + 6'd1;
            end
          end
        end
      end
      S_FIN: begin
        if (stat_i.can_emit) begin
          cmd_o.op = OP_FIN;
          if (cnt_q == FIN_LAST) begin
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      hcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hcnt_q  <= hcnt_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pngenc_dp.sv]
// pngenc_dp: config registers, length math, CRC-32, Adler-32, counters and output register.
// Depends on pngenc_pkg; commanded by pngenc_ctrl.
`default_nettype none
module pngenc_dp #(
  parameter int unsigned DIM_BITS = pngenc_pkg::DIM_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pngenc_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [pngenc_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic [7:0]                    alpha_i,
  input  pngenc_pkg::cmd_t              cmd_i,
  output pngenc_pkg::stat_t             stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o
);
  import pngenc_pkg::*;

  localparam int unsigned DW    = DIM_BITS + 1;
  localparam int unsigned LIM   = 1 << DIM_BITS;
  localparam int unsigned RAW_W = (2 * DW + 3 > 34) ? 2 * DW + 3 : 34;

  logic [CFG_W-1:0]    w_cfg_q, h_cfg_q;
  logic [DW-1:0]       w_eff, h_eff;
  logic [RAW_W-1:0]    raw_q, blk_q, blk_x;
  logic [31:0]         zlen_q;
  logic                busy_q, last_q;
  logic [31:0]         crc_q, crc_base;
  logic [15:0]         adl_l_q, adl_h_q;
  logic [16:0]         adl_l_s, adl_h_s;
  logic [15:0]         adl_l_n, adl_h_n;
  logic [DIM_BITS-1:0] col_q, row_q;
  logic [DW-1:0]       col_n, row_n;
  logic [15:0]         blk_left_q, blk_n;
  logic [RAW_W-1:0]    raw_left_q;
  logic [7:0]          red_q, green_q, blue_q, alpha_q;
  logic [7:0]          byte_d;
  logic                crc_en, crc_seed, emit;
  logic                ovalid_q, olast_q;
  logic [7:0]          obyte_q;
  logic [5:0]          k;

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return DW'(1);
    if (32'(v) > LIM) return DW'(LIM);
    return DW'(v);
  endfunction

  assign w_eff = eff_dim(w_cfg_q);
  assign h_eff = eff_dim(h_cfg_q);
  assign emit  = (cmd_i.op != OP_NONE);
  assign k     = cmd_i.idx;

  // block length of the next stored block
  assign blk_n = (raw_left_q < RAW_W'(BLOCK_MAX)) ? raw_left_q[15:0] : BLOCK_MAX;

  // ceil(raw / 65535) via reciprocal: floor(x/65535) = (x + (x>>16) + 1) >> 16
  assign blk_x = raw_q + RAW_W'(BLOCK_MAX) - RAW_W'(1);

  // free-running length math; settles while the block is idle
  always_ff @(posedge clk_i) begin
    raw_q  <= RAW_W'(h_eff) * RAW_W'({w_eff, 2'b01});
    blk_q  <= (blk_x + (blk_x >> 16) + RAW_W'(1)) >> 16;
    zlen_q <= 32'(raw_q + (blk_q << 2) + blk_q + RAW_W'(6));
  end

  // byte select and CRC coverage
  always_comb begin
    byte_d   = 8'h00;
    crc_en   = 1'b0;
    crc_seed = 1'b0;
    unique case (cmd_i.op)
      OP_START: begin
        if (k < ST_LEN) begin
          byte_d = 8'(PNG_SIG >> {~k[2:0], 3'b000});
        end else if (k < ST_IHDR_TYPE) begin
          byte_d = (k == ST_IHDR_TYPE - 6'd1) ? 8'd13 : 8'd0;
        end else if (k < ST_IHDR_DATA) begin
          byte_d   = be_byte(TYPE_IHDR, 2'(k - ST_IHDR_TYPE));
          crc_en   = 1'b1;
          crc_seed = (k == ST_IHDR_TYPE);
        end else if (k < ST_IHDR_CRC) begin
          crc_en = 1'b1;
          unique case (4'(k - ST_IHDR_DATA))
            4'd2:    byte_d = be_byte(32'(w_eff), 2'd2);
            4'd3:    byte_d = be_byte(32'(w_eff), 2'd3);
            4'd6:    byte_d = be_byte(32'(h_eff), 2'd2);
            4'd7:    byte_d = be_byte(32'(h_eff), 2'd3);
            4'd8:    byte_d = 8'd8;
            4'd9:    byte_d = 8'd6;
            default: byte_d = 8'd0;
          endcase
        end else if (k < ST_ZLEN) begin
          byte_d = be_byte(crc_q ^ ALL_ONES, 2'(k - ST_IHDR_CRC));
        end else if (k < ST_IDAT_TYPE) begin
          byte_d = be_byte(zlen_q, 2'(k - ST_ZLEN));
        end else if (k < ST_ZLIB) begin
          byte_d   = be_byte(TYPE_IDAT, 2'(k - ST_IDAT_TYPE));
          crc_en   = 1'b1;
          crc_seed = (k == ST_IDAT_TYPE);
        end else begin
          byte_d = (k == ST_ZLIB) ? ZLIB_CMF : ZLIB_FLG;
          crc_en = 1'b1;
        end
      end
      OP_HDR: begin
        crc_en = 1'b1;
        unique case (k[2:0])
          3'd0:    byte_d = {7'd0, raw_left_q <= RAW_W'(BLOCK_MAX)};
          3'd1:    byte_d = blk_n[7:0];
          3'd2:    byte_d = blk_n[15:8];
          3'd3:    byte_d = ~blk_n[7:0];
          default: byte_d = ~blk_n[15:8];
        endcase
      end
      OP_RAW: begin
        crc_en = 1'b1;
        unique case (k[2:0])
          3'd1:    byte_d = red_q;
          3'd2:    byte_d = green_q;
          3'd3:    byte_d = blue_q;
          3'd4:    byte_d = alpha_q;
          default: byte_d = 8'h00;
        endcase
      end
      OP_FIN: begin
        if (k < FIN_CRC) begin
          byte_d = be_byte({adl_h_q, adl_l_q}, 2'(k));
          crc_en = 1'b1;
        end else if (k < FIN_IEND_LEN) begin
          byte_d = be_byte(crc_q ^ ALL_ONES, 2'(k - FIN_CRC));
        end else if (k < FIN_IEND_TYPE) begin
          byte_d = 8'd0;
        end else if (k < FIN_IEND_CRC) begin
          byte_d   = be_byte(TYPE_IEND, 2'(k - FIN_IEND_TYPE));
          crc_en   = 1'b1;
          crc_seed = (k == FIN_IEND_TYPE);
        end else begin
          byte_d = be_byte(crc_q ^ ALL_ONES, 2'(k - FIN_IEND_CRC));
        end
      end
      default: byte_d = 8'h00;
    endcase
  end

  assign crc_base = crc_seed ? ALL_ONES : crc_q;

  // Adler-32 step on one raw byte
  always_comb begin
    adl_l_s = {1'b0, adl_l_q} + {9'd0, byte_d};
    adl_l_n = (adl_l_s >= ADLER_MOD) ? 16'(adl_l_s - ADLER_MOD) : adl_l_s[15:0];
    adl_h_s = {1'b0, adl_h_q} + {1'b0, adl_l_n};
    adl_h_n = (adl_h_s >= ADLER_MOD) ? 16'(adl_h_s - ADLER_MOD) : adl_h_s[15:0];
  end

  assign col_n = DW'(col_q) + DW'(1);
  assign row_n = DW'(row_q) + DW'(1);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_cfg_q  <= CFG_W'(1);
      h_cfg_q  <= CFG_W'(1);
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i && !busy_q) begin
        if (cfg_idx_i == REG_WIDTH) w_cfg_q <= cfg_data_i;
        if (cfg_idx_i == REG_HEIGHT) h_cfg_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_START && k == ST_LAST) busy_q <= 1'b1;
      if (cmd_i.op == OP_FIN && k == FIN_LAST) busy_q <= 1'b0;
      if (emit) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  // running checksums, counters and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      alpha_q <= alpha_i;
      last_q  <= (col_n >= w_eff) && (row_n >= h_eff);
    end
    if (emit) begin
      obyte_q <= byte_d;
      olast_q <= cmd_i.last;
    end
    if (crc_en) crc_q <= crc_byte(crc_base, byte_d);
    if (cmd_i.op == OP_FIN && k == FIN_LAST) crc_q <= ALL_ONES;
    if (cmd_i.op == OP_START && k == ST_LAST) begin
      adl_l_q    <= 16'd1;
      adl_h_q    <= 16'd0;
      col_q      <= '0;
      row_q      <= '0;
      blk_left_q <= '0;
      raw_left_q <= raw_q;
    end
    if (cmd_i.op == OP_HDR && k[2:0] == HDR_LAST) blk_left_q <= blk_n;
    if (cmd_i.op == OP_RAW) begin
      adl_l_q <= adl_l_n;
      adl_h_q <= adl_h_n;
      if (blk_left_q != '0) blk_left_q <= blk_left_q - 16'd1;
      if (raw_left_q != '0) raw_left_q <= raw_left_q - RAW_W'(1);
      if (k[2:0] == RAW_LAST) begin
        if (col_n >= w_eff) begin
          col_q <= '0;
          row_q <= (row_n >= h_eff) ? '0 : row_n[DIM_BITS-1:0];
        end else begin
          col_q <= col_n[DIM_BITS-1:0];
        end
      end
    end
  end

  assign stat_o = '{busy: busy_q, blk_zero: (blk_left_q == '0), col_zero: (col_q == '0),
                    img_last: last_q, can_emit: (!ovalid_q || out_ready_i)};

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule
`default_nettype wire

[hw/rtl/png_stream_encoder_stored_unit.sv]
// Top level of the PNG stream encoder (RGBA8, stored deflate blocks).
// Depends on pngenc_pkg, pngenc_if, pngenc_ctrl and pngenc_dp.
//
// A start item produces the 43-byte file head (signature, IHDR with CRC, IDAT length,
// "IDAT", zlib header); a pixel item produces its four samples, plus a filter byte at
// each row start, a 5-byte stored header when a stored block (at most 65535 bytes)
// opens, and on the last pixel the 20-byte trailer (Adler-32, IDAT CRC, IEND). The
// output runs at one byte per cycle while the receiver is ready, through a single output
// register; a new item is taken only after all bytes of the last are in that register.
// Width and height are written only between images; pixels outside an image are dropped.
`default_nettype none
module png_stream_encoder_stored_unit #(
  parameter int unsigned DIM_BITS = pngenc_pkg::DIM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pngenc_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [pngenc_pkg::CFG_W-1:0] cfg_data_i,
  pngenc_pix_if.sink                   pix_i,
  pngenc_byte_if.source                byte_o
);
  import pngenc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pngenc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_cmd_i   (pix_i.cmd),
    .in_ready_o (pix_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pngenc_dp #(.DIM_BITS(DIM_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .alpha_i     (pix_i.alpha),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (byte_o.ready),
    .out_valid_o (byte_o.valid),
    .out_byte_o  (byte_o.out_byte),
    .out_last_o  (byte_o.run_last)
  );

endmodule
`default_nettype wire

[hw/rtl/pngenc_chk.sv]
// pngenc_chk: port-level checks of the PNG encoder, bound to the top level.
// Depends on pngenc_pkg and pngenc_if.
`default_nettype none
module pngenc_chk (
  input logic             clk_i,
  input logic             rst_ni,
  pngenc_pix_if.sink      pix_i,
  pngenc_byte_if.source   byte_o
);
  import pngenc_pkg::*;

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_o.valid && !byte_o.ready |=> byte_o.valid && $stable(byte_o.out_byte)
      && $stable(byte_o.run_last))
    else $error("output byte changed under stall");

  // a start item keeps the input closed while its head is produced
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready && pix_i.cmd == CMD_START |=> !pix_i.ready)
    else $error("input open right after start");

  // no new item while the current one still has bytes to deliver
  a_run_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_o.valid && !byte_o.run_last |-> !pix_i.ready)
    else $error("input open in the middle of a run");

endmodule

bind png_stream_encoder_stored_unit pngenc_chk u_pngenc_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .pix_i  (pix_i),
  .byte_o (byte_o)
);
`default_nettype wire

[test/pngenc_tb_pkg.sv]
// Predictor of the PNG stream encoder: running CRC-32, Adler-32 and raster state.
// Depends on pngenc_pkg for register and command codes.
`timescale 1ns / 1ps
package pngenc_tb_pkg;
  import pngenc_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } png_byte_t;

  typedef enum logic {IMG_IDLE, IMG_OPEN} img_state_e;

  int unsigned dim_bits = 14;
  logic [14:0] reg_width, reg_height;
  img_state_e  img_state;
  logic [31:0] crc_acc;
  logic [15:0] adl_lo, adl_hi;
  int unsigned col_cnt, row_cnt, blk_left;
  longint unsigned bytes_left;
  png_byte_t   run_bytes[$];

  function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  function automatic int unsigned dim_used(logic [14:0] v);
    int unsigned lim;
    lim = 1 << dim_bits;
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic void put(logic [7:0] b);
    run_bytes.push_back('{b, 1'b0});
  endfunction

  function automatic void put_crc(logic [7:0] b);
    crc_acc = crc_next(crc_acc, b);
    put(b);
  endfunction

  function automatic void put32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) put(v[8*i +: 8]);
  endfunction

  function automatic void put32_crc(logic [31:0] v);
    for (int i = 3; i >= 0; i--) put_crc(v[8*i +: 8]);
  endfunction

  function automatic void enc_reset();
    reg_width = 1; reg_height = 1; img_state = IMG_IDLE; crc_acc = '1;
    adl_lo = 1; adl_hi = 0; col_cnt = 0; row_cnt = 0; blk_left = 0; bytes_left = 0;
  endfunction

  function automatic void enc_write(logic idx, logic [14:0] val);
    if (img_state != IMG_IDLE) return;
    if (idx == REG_WIDTH) reg_width = val;
    else reg_height = val;
  endfunction

  // one deflate payload byte, opening a stored block when needed
  function automatic void raw_put(logic [7:0] b);
    int unsigned n;
    logic [31:0] s;
    if (blk_left == 0) begin
      n = (bytes_left < 65535) ? int'(bytes_left) : 65535;
      put_crc((bytes_left <= 65535) ? 8'd1 : 8'd0);
      put_crc(n[7:0]); put_crc(n[15:8]);
      put_crc(~n[7:0]); put_crc(~n[15:8]);
      blk_left = n;
    end
    put_crc(b);
    if (blk_left > 0) blk_left--;
    if (bytes_left > 0) bytes_left--;
    s = adl_lo + b;
    if (s >= 65521) s -= 65521;
    adl_lo = s;
    s = adl_hi + adl_lo;
    if (s >= 65521) s -= 65521;
    adl_hi = s;
  endfunction

  // expected bytes for one accepted item
  function automatic void enc_item(logic cmd, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] bl, logic [7:0] a);
    int unsigned w, h;
    longint unsigned raw, zlen;
    w = dim_used(reg_width);
    h = dim_used(reg_height);
    run_bytes.delete();
    if (cmd == CMD_START) begin
      raw = longint'(h) * (1 + 4 * longint'(w));
      zlen = 2 + raw + 5 * ((raw + 65534) / 65535) + 4;
      put32(32'h89504E47); put32(32'h0D0A1A0A);
      put32(32'd13);
      crc_acc = '1;
      put32_crc(32'h49484452);
      put32_crc(w); put32_crc(h);
      put_crc(8); put_crc(6); put_crc(0); put_crc(0); put_crc(0);
      put32(crc_acc ^ '1);
      put32(zlen[31:0]);
      crc_acc = '1;
      put32_crc(32'h49444154);
      put_crc(8'h78); put_crc(8'h01);
      adl_lo = 1; adl_hi = 0; col_cnt = 0; row_cnt = 0; blk_left = 0;
      bytes_left = raw; img_state = IMG_OPEN;
    end else if (img_state == IMG_OPEN) begin
      if (col_cnt == 0) raw_put(8'd0);
      raw_put(r); raw_put(g); raw_put(bl); raw_put(a);
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        if (row_cnt + 1 >= h) begin
          row_cnt = 0;
          put_crc(adl_hi[15:8]); put_crc(adl_hi[7:0]);
          put_crc(adl_lo[15:8]); put_crc(adl_lo[7:0]);
          put32(crc_acc ^ '1);
          put32(32'd0);
          crc_acc = '1;
          put32_crc(32'h49454E44);
          put32(crc_acc ^ '1);
          crc_acc = '1;
          img_state = IMG_IDLE;
        end else row_cnt++;
      end
    end
    if (run_bytes.size() > 0) run_bytes[run_bytes.size()-1].run_last = 1'b1;
  endfunction
endpackage

[test/testbench.sv]
// Testbench of png_stream_encoder_stored_unit: directed and random images, checked
// byte by byte against a predictor. Depends on pngenc_pkg, pngenc_if and pngenc_tb_pkg.
`timescale 1ns / 1ps
module testbench;
  import pngenc_pkg::*;
  import pngenc_tb_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_idx_i = 0;
  logic [14:0] cfg_data_i = 0;
  pngenc_pix_if  pix();
  pngenc_byte_if bytes();

  png_byte_t expected_bytes[$];
  int unsigned errors = 0, bytes_seen = 0, items_sent = 0, images_done = 0;
  int unsigned cycle_cnt = 0;
  bit hold_sink = 0;

  png_stream_encoder_stored_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix_i(pix.sink), .byte_o(bytes.source)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    pix.valid = 0; pix.cmd = 0; pix.red = 0; pix.green = 0; pix.blue = 0; pix.alpha = 0;
    bytes.ready = 0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 600000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // output stall pattern, with a long hold when asked
  initial begin
    int unsigned g;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        bytes.ready <= 0;
        repeat (300) @(posedge clk_i);
        hold_sink = 0;
      end
      if ($urandom_range(0, 3) != 0) bytes.ready <= 1;
      else begin
        bytes.ready <= 0;
        g = gap_len();
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // byte checker
  always @(posedge clk_i) begin
    png_byte_t e;
    if (rst_ni && bytes.valid && bytes.ready) begin
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte %h last %b", $time, bytes.out_byte, bytes.run_last);
      end else begin
        e = expected_bytes.pop_front();
        if (e.out_byte !== bytes.out_byte || e.run_last !== bytes.run_last) begin
          errors++;
          $display("%0t: expected byte %h last %b, got %h last %b", $time,
                   e.out_byte, e.run_last, bytes.out_byte, bytes.run_last);
        end
      end
    end
  end

  task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [7:0] a, bit gaps);
    int unsigned n;
    n = gaps ? gap_len() : 0;
    if (gaps && $urandom_range(0, 2) == 0) n = 0;
    repeat (n) begin
      pix.valid <= 0;
      @(posedge clk_i);
    end
    pix.valid <= 1; pix.cmd <= cmd; pix.red <= r; pix.green <= g;
    pix.blue <= b; pix.alpha <= a;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    enc_item(cmd, r, g, b, a);
    foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
    if (cmd == CMD_PIXEL && run_bytes.size() > 20) images_done++;
    items_sent++;
  endtask

  task automatic send_pixel(bit gaps);
    send_item(CMD_PIXEL, $urandom, $urandom, $urandom, $urandom, gaps);
  endtask

  task automatic drain();
    pix.valid <= 0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    enc_write(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_size(logic [14:0] w, logic [14:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic full_image(int unsigned npix, bit gaps);
    send_item(CMD_START, $urandom, $urandom, $urandom, $urandom, gaps);
    repeat (npix) send_pixel(gaps);
  endtask

  // reset sizes, idle pixels, sample extremes
  task automatic test_basics();
    send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    full_image(1, 0);
    drain();
    set_size(0, 0);
    full_image(1, 0);
    send_item(CMD_START, 0, 0, 0, 0, 0);
    send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    drain();
    set_size(3, 2);
    full_image(2, 0);
    drain();
    write_reg(REG_WIDTH, 7);                  // ignored, image open
    repeat (4) send_pixel(0);
    drain();
  endtask

  // oversized dimensions: header and length only, image left open then restarted
  task automatic test_large_sizes();
    set_size(15'h7FFF, 15'h7FFF);
    send_item(CMD_START, 0, 0, 0, 0, 0);
    repeat (3) send_pixel(0);
    send_item(CMD_START, 0, 0, 0, 0, 0);
    repeat (2) send_pixel(0);
    drain();
  endtask

  // long receiver hold while the sender keeps offering pixels
  task automatic test_backpressure();
    set_size(4, 4);
    send_item(CMD_START, 0, 0, 0, 0, 0);
    hold_sink = 1;
    repeat (16) send_pixel(0);
    drain();
  endtask

  // random images with random gaps and stray items
  task automatic test_random();
    int unsigned w, h, n;
    while (items_sent < 360) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 5);
      h = $urandom_range(0, 4);
      set_size(w, h);
      n = dim_used(w) * dim_used(h);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
      if ($urandom_range(0, 9) == 0) send_pixel(1);
      full_image(n, 1);
      drain();
    end
  endtask

  initial begin
    enc_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_basics();
    test_backpressure();
    test_random();
    test_large_sizes();
    $display("Sent %0d items, checked %0d bytes, %0d complete images with trailers.",
             items_sent, bytes_seen, images_done);
    $display("Covered size clamping, restarts, stray pixels, gaps and a long output hold.");
    if (errors == 0 && expected_bytes.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
